@@ hdl/yaw_pd_steering_controller_assert.svh @@
// assertion macros shared by the yaw steering controller modules
`ifndef YAW_PD_STEERING_CONTROLLER_ASSERT_SVH
`define YAW_PD_STEERING_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define YPSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ypsc: same-cycle check failed");

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define YPSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ypsc: next-cycle check failed");

`endif

@@ hdl/ypsc_pkg.sv @@
// shared types, constants and helpers of the yaw steering controller
`default_nettype none
package ypsc_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEER_LIM  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_LIM   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_LIM   = 3'd4;

    localparam logic [15:0] RST_GAIN_PROP  = 16'd256;
    localparam logic [15:0] RST_GAIN_DERIV = 16'd0;
    localparam logic [14:0] RST_STEER_LIM  = 15'd4096;
    localparam logic [14:0] RST_STEP_LIM   = 15'd0;
    localparam logic [15:0] RST_RATE_LIM   = 16'd23040;

    // stream widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int USER_W     = 2;

    // fixed point constants
    localparam logic signed [17:0] PI_Q12     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic [19:0]        DT_MIN_US  = 20'd1000;
    localparam logic [19:0]        DT_MAX_US  = 20'd100000;
    localparam logic [14:0]        ONE_Q14    = 15'd16384;

    // shared multiplier
    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = 47;
    localparam logic [MUL_B_W-1:0]        DERIV_SCALE = 25'd100000;
    localparam logic [MUL_B_W-1:0]        RATE_SCALE  = 25'd20828160;
    localparam logic signed [MUL_A_W-1:0] PI_DEN      = 22'sd355;

    // shared divider
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 25;
    localparam int DIV_CNT_W = 6;
    localparam int DIV_YAW_BITS = 31;
    localparam int DIV_YAW_PAD  = DIV_NUM_W - DIV_YAW_BITS;
    localparam logic [DIV_CNT_W-1:0] DIV_ITERS_YAW  = 6'd31;
    localparam logic [DIV_CNT_W-1:0] DIV_ITERS_RATE = 6'd40;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] iters;
    } t_div_req;

    // wrap an angle difference to [-pi, pi), one correction is enough here
    function automatic logic signed [14:0] wrap_pi(input logic signed [16:0] x);
        logic signed [17:0] y;
        y = $signed({x[16], x}) + PI_Q12;
        if (y >= TWO_PI_Q12) begin
            y = y - TWO_PI_Q12;
        end else if (y < 18'sd0) begin
            y = y + TWO_PI_Q12;
        end
        y = y - PI_Q12;
        return y[14:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/ypsc_mul.sv @@
// shared signed by unsigned multiplier with registered product
`default_nettype none
module ypsc_mul
    import ypsc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire t_mul_req                    i_req,
    output logic signed [MUL_P_W-1:0]        o_prod
);

    logic signed [MUL_A_W+MUL_B_W:0] w_full;
    logic signed [MUL_P_W-1:0]       r_prod;

    assign w_full = i_req.a * $signed({1'b0, i_req.b});

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[MUL_P_W-1:0];
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

@@ hdl/ypsc_div.sv @@
// shared restoring divider, one quotient bit per cycle
`default_nettype none
`include "yaw_pd_steering_controller_assert.svh"
module ypsc_div
    import ypsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_div_req              i_req,
    output logic                       o_done,
    output logic [DIV_NUM_W-1:0]       o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quot;

    logic [DIV_DEN_W:0] w_shift;
    logic [DIV_DEN_W:0] w_sub;
    logic               w_ge;

    // bring down the next numerator bit and trial subtract
    assign w_shift = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_den  <= i_req.den;
            r_num  <= i_req.num;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `YPSC_ASSERT_IMP(a_div_no_restart, i_req.start, !r_busy)
    `YPSC_ASSERT_IMP(a_div_count_live, r_busy, r_cnt != '0)

endmodule
`default_nettype wire

@@ hdl/yaw_pd_steering_controller.sv @@
// yaw pd steering controller: no setpoint gives zero steering; a zero limit skips its divider pass
// yaw mode runs two 31-step divider passes, for the derivative and for normalising the steering
// rate mode runs one 40-step divider pass; one item is worked at a time and input is held off
// the next item is taken while a finished item still waits in the output register
// i_rst_n is synchronous, active low: registers to reset values, stored error and steering zero
`default_nettype none
`include "yaw_pd_steering_controller_assert.svh"
module yaw_pd_steering_controller
    import ypsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input items
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // elapsed_us[19:0], measured_yaw[34:20], yaw_target[49:35], rate_target[65:50], zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // yaw_target_valid[0], rate_target_valid[1]
    input  wire logic [USER_W-1:0]     i_s_axis_tuser,
    // result items
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // normalized_steering[15:0], yaw_echo[30:16], yaw_target_echo[45:31], zero pad
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // steering_valid[0], yaw_target_echo_valid[1]
    output logic [USER_W-1:0]          o_m_axis_tuser
);

    // sequencer steps
    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_ERR   = 15'b000000000000010,
        ST_DERR  = 15'b000000000000100,
        ST_DMUL  = 15'b000000000001000,
        ST_DNUM  = 15'b000000000010000,
        ST_PACC  = 15'b000000000100000,
        ST_DDIV  = 15'b000000001000000,
        ST_DACC  = 15'b000000010000000,
        ST_STEER = 15'b000000100000000,
        ST_SLEW  = 15'b000001000000000,
        ST_NDIV  = 15'b000010000000000,
        ST_NWAIT = 15'b000100000000000,
        ST_RNUM  = 15'b001000000000000,
        ST_RDEN  = 15'b010000000000000,
        ST_OUT   = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [15:0] r_gain_prop;
    logic [15:0] r_gain_deriv;
    logic [14:0] r_steer_lim;
    logic [14:0] r_step_lim;
    logic [15:0] r_rate_lim;

    // latched item
    logic [16:0]        r_dt;
    logic signed [14:0] r_yaw;
    logic signed [14:0] r_tgt;
    logic               r_tgt_ok;
    logic signed [15:0] r_rate;
    logic               r_rate_ok;

    // controller state carried between items
    logic signed [15:0] r_prev_err;
    logic signed [15:0] r_prev_steer;

    // working registers
    logic signed [14:0] r_err;
    logic signed [14:0] r_derr;
    logic               r_neg;
    logic signed [40:0] r_acc;
    logic signed [15:0] r_steer;
    logic signed [15:0] r_norm;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [USER_W-1:0]     r_out_user;

    // shared units
    t_mul_req                  w_mul_req;
    t_div_req                  w_div_req;
    logic signed [MUL_P_W-1:0] w_prod;
    logic                      w_div_done;
    logic [DIV_NUM_W-1:0]      w_quot;

    logic w_in_take;
    logic w_out_load;

    // input field slices
    logic [19:0]        w_in_dt;
    logic [16:0]        w_dt_clamped;

    // datapath helpers
    logic signed [16:0]  w_diff_tgt;
    logic signed [16:0]  w_diff_err;
    logic [MUL_P_W-1:0]  w_prod_mag;
    logic [30:0]         w_dnum;
    logic [40:0]         w_acc_mag;
    logic [40:0]         w_acc_rnd;
    logic [32:0]         w_steer_sh;
    logic [14:0]         w_steer_sat;
    logic signed [15:0]  w_steer_new;
    logic signed [16:0]  w_sdiff;
    logic signed [16:0]  w_sdiff_lim;
    logic signed [16:0]  w_slew_sum;
    logic [14:0]         w_steer_mag;
    logic [30:0]         w_nnum;
    logic [DIV_NUM_W-1:0] w_rnum;
    logic [14:0]         w_norm_mag;
    logic signed [15:0]  w_norm_new;
    logic signed [14:0]  w_tgt_echo;

    ypsc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    ypsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // handshakes
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == ST_OUT) && (!r_out_valid || i_m_axis_tready);

    // elapsed time held to 1 ms .. 100 ms
    assign w_in_dt = i_s_axis_tdata[19:0];
    always_comb begin
        if (w_in_dt < DT_MIN_US) begin
            w_dt_clamped = DT_MIN_US[16:0];
        end else if (w_in_dt > DT_MAX_US) begin
            w_dt_clamped = DT_MAX_US[16:0];
        end else begin
            w_dt_clamped = w_in_dt[16:0];
        end
    end

    // yaw error and its change, both wrapped to +-pi
    assign w_diff_tgt = $signed({{2{r_tgt[14]}}, r_tgt}) - $signed({{2{r_yaw[14]}}, r_yaw});
    assign w_diff_err = $signed({{2{r_err[14]}}, r_err}) - $signed({r_prev_err[15], r_prev_err});

    // magnitude of the latest product for round-to-nearest division
    assign w_prod_mag = w_prod[MUL_P_W-1] ? MUL_P_W'(-w_prod) : MUL_P_W'(w_prod);
    // |de * 100000| + dt/2, below 2^31
    assign w_dnum     = w_prod_mag[30:0] + {14'd0, r_dt[16:1]};

    // steering: round(-acc / 256) held to the steering limit
    assign w_acc_mag   = r_acc[40] ? 41'(-r_acc) : 41'(r_acc);
    assign w_acc_rnd   = w_acc_mag + 41'd128;
    assign w_steer_sh  = w_acc_rnd[40:8];
    assign w_steer_sat = (w_steer_sh > {18'd0, r_steer_lim}) ? r_steer_lim : w_steer_sh[14:0];
    assign w_steer_new = r_acc[40] ? $signed({1'b0, w_steer_sat})
                                   : -$signed({1'b0, w_steer_sat});

    // slew limit against the last steering
    assign w_sdiff = $signed({r_steer[15], r_steer}) - $signed({r_prev_steer[15], r_prev_steer});
    always_comb begin
        if (w_sdiff > $signed({2'b00, r_step_lim})) begin
            w_sdiff_lim = $signed({2'b00, r_step_lim});
        end else if (w_sdiff < -$signed({2'b00, r_step_lim})) begin
            w_sdiff_lim = -$signed({2'b00, r_step_lim});
        end else begin
            w_sdiff_lim = w_sdiff;
        end
    end
    assign w_slew_sum = $signed({r_prev_steer[15], r_prev_steer}) + w_sdiff_lim;

    // normalising numerator |s| * 2^14 + lim/2
    assign w_steer_mag = r_steer[15] ? 15'(-r_steer) : r_steer[14:0];
    assign w_nnum      = {2'b00, w_steer_mag, 14'd0} + {17'd0, r_steer_lim[14:1]};

    // rate numerator |rate * scale| + den/2, den is the product of 355 and the rate limit
    assign w_rnum = w_acc_mag[DIV_NUM_W-1:0] + {16'd0, w_prod[24:1]};

    // quotient to +-1.0 in Q1.14
    assign w_norm_mag = (w_quot > {25'd0, ONE_Q14}) ? ONE_Q14 : w_quot[14:0];
    assign w_norm_new = r_neg ? -$signed({1'b0, w_norm_mag}) : $signed({1'b0, w_norm_mag});

    assign w_tgt_echo = r_tgt_ok ? r_tgt : 15'sd0;

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_req.a = '0;
        w_mul_req.b = '0;
        case (r_state)
            ST_ERR: begin
                w_mul_req.a = {{(MUL_A_W-16){r_rate[15]}}, r_rate};
                w_mul_req.b = RATE_SCALE;
            end
            ST_DMUL: begin
                w_mul_req.a = {{(MUL_A_W-15){r_derr[14]}}, r_derr};
                w_mul_req.b = DERIV_SCALE;
            end
            ST_DNUM: begin
                w_mul_req.a = {{(MUL_A_W-15){r_err[14]}}, r_err};
                w_mul_req.b = {9'd0, r_gain_prop};
            end
            ST_DDIV: begin
                // derivative magnitude, sign applied at accumulation
                w_mul_req.a = {1'b0, w_quot[20:0]};
                w_mul_req.b = {9'd0, r_gain_deriv};
            end
            ST_RNUM: begin
                w_mul_req.a = PI_DEN;
                w_mul_req.b = {9'd0, r_rate_lim};
            end
            default: begin
                w_mul_req.a = '0;
                w_mul_req.b = '0;
            end
        endcase
    end

    // divider start and operands
    always_comb begin
        w_div_req.start = 1'b0;
        w_div_req.num   = '0;
        w_div_req.den   = '0;
        w_div_req.iters = '0;
        case (r_state)
            ST_DNUM: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = {w_dnum, {DIV_YAW_PAD{1'b0}}};
                w_div_req.den   = {8'd0, r_dt};
                w_div_req.iters = DIV_ITERS_YAW;
            end
            ST_NDIV: begin
                w_div_req.start = (r_steer_lim != '0);
                w_div_req.num   = {w_nnum, {DIV_YAW_PAD{1'b0}}};
                w_div_req.den   = {10'd0, r_steer_lim};
                w_div_req.iters = DIV_ITERS_YAW;
            end
            ST_RDEN: begin
                w_div_req.start = (r_rate_lim != '0);
                w_div_req.num   = w_rnum;
                w_div_req.den   = w_prod[DIV_DEN_W-1:0];
                w_div_req.iters = DIV_ITERS_RATE;
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_in_take) n_state = ST_ERR;
            ST_ERR: begin
                if (r_tgt_ok) begin
                    n_state = ST_DERR;
                end else if (r_rate_ok) begin
                    n_state = ST_RNUM;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DERR:  n_state = ST_DMUL;
            ST_DMUL:  n_state = ST_DNUM;
            ST_DNUM:  n_state = ST_PACC;
            ST_PACC:  n_state = ST_DDIV;
            ST_DDIV:  if (w_div_done) n_state = ST_DACC;
            ST_DACC:  n_state = ST_STEER;
            ST_STEER: n_state = ST_SLEW;
            ST_SLEW:  n_state = ST_NDIV;
            ST_NDIV:  n_state = (r_steer_lim != '0) ? ST_NWAIT : ST_OUT;
            ST_NWAIT: if (w_div_done) n_state = ST_OUT;
            ST_RNUM:  n_state = ST_RDEN;
            ST_RDEN:  n_state = (r_rate_lim != '0) ? ST_NWAIT : ST_OUT;
            ST_OUT:   if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state, configuration and stored controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_prev_err   <= '0;
            r_prev_steer <= '0;
            r_gain_prop  <= RST_GAIN_PROP;
            r_gain_deriv <= RST_GAIN_DERIV;
            r_steer_lim  <= RST_STEER_LIM;
            r_step_lim   <= RST_STEP_LIM;
            r_rate_lim   <= RST_RATE_LIM;
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_SLEW) begin
                r_prev_err   <= {r_err[14], r_err};
                r_prev_steer <= r_steer;
                if (r_step_lim != '0) begin
                    r_prev_steer <= w_slew_sum[15:0];
                end
            end else if (r_state == ST_RDEN) begin
                // rate mode restarts the derivative
                r_prev_err <= '0;
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_GAIN_PROP:  r_gain_prop  <= i_cfg_wdata;
                    REG_GAIN_DERIV: r_gain_deriv <= i_cfg_wdata;
                    REG_STEER_LIM:  r_steer_lim  <= i_cfg_wdata[14:0];
                    REG_STEP_LIM:   r_step_lim   <= i_cfg_wdata[14:0];
                    REG_RATE_LIM:   r_rate_lim   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    r_dt      <= w_dt_clamped;
                    r_yaw     <= $signed(i_s_axis_tdata[34:20]);
                    r_tgt     <= $signed(i_s_axis_tdata[49:35]);
                    r_rate    <= $signed(i_s_axis_tdata[65:50]);
                    r_tgt_ok  <= i_s_axis_tuser[0];
                    r_rate_ok <= i_s_axis_tuser[1];
                end
            end
            ST_ERR: begin
                r_err  <= wrap_pi(w_diff_tgt);
                r_norm <= '0;
            end
            ST_DERR: r_derr <= wrap_pi(w_diff_err);
            ST_DNUM: r_neg  <= w_prod[MUL_P_W-1];
            ST_PACC: r_acc  <= w_prod[40:0];
            ST_DACC: begin
                if (r_neg) begin
                    r_acc <= r_acc - w_prod[40:0];
                end else begin
                    r_acc <= r_acc + w_prod[40:0];
                end
            end
            ST_STEER: r_steer <= w_steer_new;
            ST_SLEW: begin
                if (r_step_lim != '0) begin
                    r_steer <= w_slew_sum[15:0];
                end
            end
            ST_NDIV:  r_neg <= r_steer[15];
            ST_RNUM:  r_acc <= w_prod[40:0];
            ST_RDEN:  r_neg <= r_acc[40];
            ST_NWAIT: begin
                if (w_div_done) begin
                    r_norm <= w_norm_new;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    r_out_data <= {2'b00, w_tgt_echo, r_yaw, r_norm};
                    r_out_user <= {r_tgt_ok, r_tgt_ok | r_rate_ok};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `YPSC_ASSERT_NXT(a_busy_after_take, w_in_take, !o_s_axis_tready)
    `YPSC_ASSERT_IMP(a_valid_from_out, $rose(o_m_axis_tvalid), $past(r_state == ST_OUT))
    `YPSC_ASSERT_IMP(a_idle_zero_steer, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata[15:0] == '0)

endmodule
`default_nettype wire

@@ verif/yaw_pd_steering_controller_check.sv @@
// checker for the yaw steering controller: predicts every result item and compares it
module yaw_pd_steering_controller_check
    import ypsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    input  wire logic                  i_s_axis_tready,
    // elapsed_us, measured_yaw, yaw_target, rate_target, zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // yaw_target_valid, rate_target_valid
    input  wire logic [USER_W-1:0]     i_s_axis_tuser,
    input  wire logic                  i_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // normalized_steering, yaw_echo, yaw_target_echo, zero pad
    input  wire logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    // steering_valid, yaw_target_echo_valid
    input  wire logic [USER_W-1:0]     i_m_axis_tuser,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HALF_TURN  = 12868;
    localparam int     FULL_TURN  = 25736;
    localparam longint DT_FLOOR   = 1000;
    localparam longint DT_CEIL    = 100000;
    localparam longint DERIV_US   = 100000;
    localparam longint UNIT_Q14   = 16384;
    localparam longint RATE_NUM   = 20828160;
    localparam longint PI_NUMER   = 355;
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic               steer_ok;
        logic signed [15:0] steer;
        logic [14:0]        yaw;
        logic [14:0]        tgt;
        logic               tgt_ok;
    } steer_item_t;

    logic [15:0] gain_p;
    logic [15:0] gain_d;
    logic [14:0] steer_lim;
    logic [14:0] step_lim;
    logic [15:0] rate_lim;
    int          err_held;
    int          steer_held;
    steer_item_t steering_due [$];
    int          fails = 0;
    int          seen = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // nearest, ties away from zero, den positive
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    function automatic int wrap_angle(input int x);
        int r;
        r = (x + HALF_TURN) % FULL_TURN;
        if (r < 0) begin
            r += FULL_TURN;
        end
        return r - HALF_TURN;
    endfunction

    // steering for one tick, updating the held error and steering
    function automatic steer_item_t steering_for_tick(input logic [IN_DATA_W-1:0] d,
                                                      input logic [USER_W-1:0] u);
        steer_item_t r;
        longint      dt;
        longint      deriv;
        longint      acc;
        longint      s;
        longint      lim;
        longint      step;
        longint      rate;
        longint      norm;
        int          yaw;
        int          tgt;
        int          e;
        dt   = clip(longint'(d[19:0]), DT_FLOOR, DT_CEIL);
        yaw  = $signed(d[34:20]);
        tgt  = $signed(d[49:35]);
        rate = $signed(d[65:50]);
        norm = 0;
        r.steer_ok = 1'b0;
        if (u[0]) begin
            e     = wrap_angle(tgt - yaw);
            deriv = round_div(longint'(wrap_angle(e - err_held)) * DERIV_US, dt);
            lim   = longint'(steer_lim);
            acc   = longint'(gain_p) * e + longint'(gain_d) * deriv;
            s     = clip(round_div(-acc, 256), -lim, lim);
            if (step_lim != 0) begin
                step = longint'(step_lim);
                s    = steer_held + clip(s - steer_held, -step, step);
            end
            err_held   = e;
            steer_held = int'(s);
            if (lim != 0) begin
                norm = clip(round_div(s * UNIT_Q14, lim), -UNIT_Q14, UNIT_Q14);
            end
            r.steer_ok = 1'b1;
        end else if (u[1]) begin
            if (rate_lim != 0) begin
                norm = clip(round_div(rate * RATE_NUM, PI_NUMER * longint'(rate_lim)),
                            -UNIT_Q14, UNIT_Q14);
            end
            err_held   = 0;
            r.steer_ok = 1'b1;
        end
        r.steer  = norm[15:0];
        r.yaw    = d[34:20];
        r.tgt    = u[0] ? d[49:35] : 15'd0;
        r.tgt_ok = u[0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        steer_item_t got;
        steer_item_t want;
        if (!i_rst_n) begin
            gain_p     = RST_GAIN_PROP;
            gain_d     = RST_GAIN_DERIV;
            steer_lim  = RST_STEER_LIM;
            step_lim   = RST_STEP_LIM;
            rate_lim   = RST_RATE_LIM;
            err_held   = 0;
            steer_held = 0;
            steering_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_GAIN_PROP:  gain_p    = i_cfg_wdata;
                    REG_GAIN_DERIV: gain_d    = i_cfg_wdata;
                    REG_STEER_LIM:  steer_lim = i_cfg_wdata[14:0];
                    REG_STEP_LIM:   step_lim  = i_cfg_wdata[14:0];
                    REG_RATE_LIM:   rate_lim  = i_cfg_wdata;
                    default: ;
                endcase
            end
            // results first, so an item taken at this edge never meets itself
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen++;
                got.steer_ok = i_m_axis_tuser[0];
                got.steer    = i_m_axis_tdata[15:0];
                got.yaw      = i_m_axis_tdata[30:16];
                got.tgt      = i_m_axis_tdata[45:31];
                got.tgt_ok   = i_m_axis_tuser[1];
                if (steering_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX) begin
                        $display("result %0d arrived with nothing expected", seen);
                    end
                end else begin
                    want = steering_due.pop_front();
                    if (got != want) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("result %0d: expected ok %0b steer %0d yaw %0d tgt %0d/%0b",
                                     seen, want.steer_ok, $signed(want.steer),
                                     $signed(want.yaw), $signed(want.tgt), want.tgt_ok);
                            $display("           got      ok %0b steer %0d yaw %0d tgt %0d/%0b",
                                     got.steer_ok, $signed(got.steer), $signed(got.yaw),
                                     $signed(got.tgt), got.tgt_ok);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                steering_due.push_back(steering_for_tick(i_s_axis_tdata, i_s_axis_tuser));
            end
        end
        o_fail_count <= fails;
        o_pending    <= steering_due.size();
    end

endmodule

@@ verif/yaw_pd_steering_controller_test.sv @@
// testbench top for the yaw steering controller: clock, reset, stimulus and verdict
module yaw_pd_steering_controller_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ypsc_pkg::*;

    // worst case per item adds the block's work, the longest sender gap and receiver stall,
    // over about 1350 items; the limit leaves ample headroom
    localparam int CYCLE_LIMIT = 900000;
    // cycles to let pass once nothing is expected; covers the yaw mode latency
    localparam int SETTLE      = 80;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 130;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  tick_valid = 1'b0;
    logic                  tick_ready;
    logic [IN_DATA_W-1:0]  tick_data = '0;
    logic [USER_W-1:0]     tick_user = '0;
    logic                  cmd_valid;
    logic                  cmd_ready = 1'b0;
    logic [OUT_DATA_W-1:0] cmd_data;
    logic [USER_W-1:0]     cmd_user;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int hold_left = 0;
    int cmds_taken = 0;
    int ticks_yaw = 0;
    int ticks_rate = 0;
    int ticks_idle = 0;
    int config_sets = 0;
    // stretches with the sender or the receiver running flat out
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;

    always #4 clk = ~clk;

    yaw_pd_steering_controller dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (tick_valid),
        .o_s_axis_tready (tick_ready),
        .i_s_axis_tdata  (tick_data),
        .i_s_axis_tuser  (tick_user),
        .o_m_axis_tvalid (cmd_valid),
        .i_m_axis_tready (cmd_ready),
        .o_m_axis_tdata  (cmd_data),
        .o_m_axis_tuser  (cmd_user)
    );

    yaw_pd_steering_controller_check checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (tick_valid),
        .i_s_axis_tready (tick_ready),
        .i_s_axis_tdata  (tick_data),
        .i_s_axis_tuser  (tick_user),
        .i_m_axis_tvalid (cmd_valid),
        .i_m_axis_tready (cmd_ready),
        .i_m_axis_tdata  (cmd_data),
        .i_m_axis_tuser  (cmd_user),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // run guard: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure; one assignment of cmd_ready per edge
    always @(posedge clk) begin
        if (cmd_valid && cmd_ready) begin
            cmds_taken <= cmds_taken + 1;
        end
        if (hold_left > 0) begin
            cmd_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
            cmd_ready <= 1'b0;
            hold_left <= pick_gap();
        end else begin
            cmd_ready <= 1'b1;
        end
    end

    // all five registers, written back to back while the block is idle
    task automatic write_regs(input logic [15:0] gp, input logic [15:0] gd,
                              input logic [14:0] sl, input logic [14:0] ss,
                              input logic [15:0] rl);
        logic [CFG_ADDR_W-1:0] idx [5];
        logic [15:0]           val [5];
        idx = '{REG_GAIN_PROP, REG_GAIN_DERIV, REG_STEER_LIM, REG_STEP_LIM, REG_RATE_LIM};
        val = '{gp, gd, {1'b0, sl}, {1'b0, ss}, rl};
        for (int k = 0; k < 5; k++) begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[k];
            cfg_wdata <= val[k];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        config_sets++;
    endtask

    // the pending count is updated at the edge, so it is read only after an edge has passed
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one tick item; valid is kept high into the next item when there is no gap
    task automatic send_tick(input logic [19:0] us, input logic signed [14:0] yaw,
                             input logic signed [14:0] tgt, input logic tgt_ok,
                             input logic signed [15:0] rate, input logic rate_ok);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_data  <= {6'd0, rate, tgt, yaw, us};
        tick_user  <= {rate_ok, tgt_ok};
        do @(posedge clk); while (!tick_ready);
        if (tgt_ok) begin
            ticks_yaw++;
        end else if (rate_ok) begin
            ticks_rate++;
        end else begin
            ticks_idle++;
        end
    endtask

    // mostly plausible ticks with a small heading error, a tenth pure noise
    task automatic random_tick();
        logic [19:0]        us;
        logic signed [14:0] yaw;
        logic signed [14:0] tgt;
        logic signed [15:0] rate;
        logic               tgt_ok;
        logic               rate_ok;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            us      = $urandom_range(0, 20'hFFFFF);
            yaw     = $urandom_range(0, 16'h7FFF);
            tgt     = $urandom_range(0, 16'h7FFF);
            rate    = $urandom_range(0, 16'hFFFF);
            tgt_ok  = $urandom_range(0, 1);
            rate_ok = $urandom_range(0, 1);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                us = $urandom_range(1000, 20000);
            end else if (r < 85) begin
                us = $urandom_range(20001, 100000);
            end else if (r < 92) begin
                us = $urandom_range(0, 999);
            end else begin
                us = $urandom_range(100001, 20'hFFFFF);
            end
            yaw = $urandom_range(0, 25736) - 12868;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                tgt = yaw + ($urandom_range(0, 1200) - 600);
            end else if (r < 95) begin
                tgt = $urandom_range(0, 25736) - 12868;
            end else begin
                tgt = $urandom_range(0, 16'h7FFF);
            end
            if ($urandom_range(0, 99) < 60) begin
                rate = $urandom_range(0, 16000) - 8000;
            end else begin
                rate = $urandom_range(0, 16'hFFFF);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                {tgt_ok, rate_ok} = 2'b10;
            end else if (r < 75) begin
                {tgt_ok, rate_ok} = 2'b01;
            end else if (r < 88) begin
                {tgt_ok, rate_ok} = 2'b11;
            end else begin
                {tgt_ok, rate_ok} = 2'b00;
            end
        end
        send_tick(us, yaw, tgt, tgt_ok, rate, rate_ok);
    endtask

    // register set for a phase: fixed corners first, random ones after
    task automatic load_phase(input int p);
        case (p)
            0: write_regs(16'd1024, 16'd512, 15'd4096, 15'd0, 16'd23040);
            1: write_regs(16'd2000, 16'd300, 15'd6000, 15'd200, 16'd1000);
            2: write_regs(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
            3: write_regs(16'd0, 16'd0, 15'd0, 15'd0, 16'd0);
            4: write_regs(16'd1, 16'd1, 15'd1, 15'd1, 16'd1);
            default: begin
                write_regs(($urandom_range(0, 99) < 70) ? $urandom_range(0, 4096)
                                                        : $urandom_range(0, 16'hFFFF),
                           ($urandom_range(0, 99) < 70) ? $urandom_range(0, 4096)
                                                        : $urandom_range(0, 16'hFFFF),
                           ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12868)
                                                        : $urandom_range(0, 15'h7FFF),
                           ($urandom_range(0, 99) < 40) ? 15'd0 : $urandom_range(1, 1000),
                           ($urandom_range(0, 99) < 80) ? $urandom_range(256, 46080)
                                                        : $urandom_range(0, 16'hFFFF));
            end
        endcase
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed ticks under the reset register values
        send_tick(20'd20000, 15'sd0, 15'sd0, 1'b0, 16'sd0, 1'b0);          // no setpoint
        send_tick(20'd20000, 15'sd300, 15'sd123, 1'b0, 16'sd0, 1'b0);      // target not valid
        send_tick(20'd20000, 15'sd1000, 15'sd1500, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd20000, 15'sd1000, 15'sd2000, 1'b1, 16'sd0, 1'b0);
        // elapsed time around and past both clamp points
        send_tick(20'd0, 15'sd1000, 15'sd1500, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd999, 15'sd1000, 15'sd1800, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd1000, 15'sd1000, 15'sd1200, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd100000, 15'sd1000, 15'sd1900, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd100001, 15'sd1000, 15'sd900, 1'b1, 16'sd0, 1'b0);
        send_tick(20'hFFFFF, 15'sd1000, 15'sd1600, 1'b1, 16'sd0, 1'b0);
        // large errors that hit the steering limit both ways
        send_tick(20'd5000, 15'sd0, 15'sd12000, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd5000, 15'sd0, -15'sd12000, 1'b1, 16'sd0, 1'b0);
        // error across the half turn, then inputs beyond their range
        send_tick(20'd5000, -15'sd12868, 15'sd12868, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd5000, 15'sd12868, -15'sd12868, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd5000, -15'sd16384, 15'sd16383, 1'b1, 16'sd0, 1'b0);
        send_tick(20'd5000, 15'sd16383, -15'sd16384, 1'b1, 16'sd0, 1'b0);
        // rate setpoint alone, extremes and small values
        send_tick(20'd5000, 15'sd0, 15'sd0, 1'b0, 16'sd32767, 1'b1);
        send_tick(20'd5000, 15'sd0, 15'sd0, 1'b0, -16'sd32768, 1'b1);
        send_tick(20'd5000, 15'sd0, 15'sd0, 1'b0, 16'sd0, 1'b1);
        send_tick(20'd5000, 15'sd0, 15'sd0, 1'b0, 16'sd100, 1'b1);
        // both setpoints: the yaw setpoint wins
        send_tick(20'd5000, 15'sd0, 15'sd500, 1'b1, -16'sd32768, 1'b1);
        send_tick(20'd5000, 15'sd500, 15'sd200, 1'b1, 16'sd1234, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            tick_valid <= 1'b0;
            wait_drained();
            load_phase(p);
            tx_gaps   = (p % 3 != 1);
            rx_stalls = (p % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // halfway through, hold the sender until everything is back
                if (n == PHASE_ITEMS / 2) begin
                    tick_valid <= 1'b0;
                    wait_drained();
                end
                random_tick();
            end
        end
        tick_valid <= 1'b0;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        wait_drained();

        $display("ran %0d ticks (%0d yaw, %0d rate, %0d without setpoint) over %0d register sets",
                 ticks_yaw + ticks_rate + ticks_idle, ticks_yaw, ticks_rate, ticks_idle,
                 config_sets);
        $display("%0d result items taken, %0d mismatches", cmds_taken, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
